/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  // power of two: offsets and sizes are split by shift and mask
  localparam int BLOCK_BYTES = 4096;

  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int BLK_SH  = $clog2(BLOCK_BYTES);
  localparam int MARK_W  = 3;
  localparam int CFG_W   = 11;
  localparam int BYTES_W = 32;
  localparam int OFF_W   = 22;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 11;
  localparam int NEED_W  = BYTES_W - BLK_SH + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef logic [MARK_W-1:0] mark_t;

  localparam mark_t MARK_FREE   = 3'd0;
  localparam mark_t MARK_USED   = 3'd1;
  localparam mark_t MARK_START  = 3'd2;
  localparam mark_t MARK_END    = 3'd3;
  localparam mark_t MARK_SINGLE = 3'd4;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NOMEM   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic               command;
    logic [BYTES_W-1:0] request_bytes;
    logic [OFF_W-1:0]   release_offset;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  alloc_offset;
    logic [OCNT_W-1:0] used_blocks;
    logic [OCNT_W-1:0] free_blocks;
  } rsp_word_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    mark_t            wr_mark;
  } mark_req_t;

endpackage

/* rtl/bba_if.sv */
// ----------------------------------------------------------------------------
// bba_if
// Handshake channels of the allocator: request, response, configuration.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bba_pkg::BYTES_W-1:0] request_bytes;
  logic [bba_pkg::OFF_W-1:0]   release_offset;

  modport source (output valid, command, request_bytes, release_offset, input ready);
  modport sink (input valid, command, request_bytes, release_offset, output ready);
endinterface

interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bba_pkg::STAT_W-1:0] status;
  logic [bba_pkg::OFF_W-1:0]  alloc_offset;
  logic [bba_pkg::OCNT_W-1:0] used_blocks;
  logic [bba_pkg::OCNT_W-1:0] free_blocks;

  modport source (output valid, status, alloc_offset, used_blocks, free_blocks,
                  input ready);
  modport sink (input valid, status, alloc_offset, used_blocks, free_blocks,
                output ready);
endinterface

interface bba_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bba_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/bba_mark_store.sv */
// ----------------------------------------------------------------------------
// bba_mark_store
// Block mark memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bba_mark_store (
  input  logic                clk,
  input  logic                rst,
  input  bba_pkg::mark_req_t  req,
  output bba_pkg::mark_t      rd_data,
  output logic                clearing
);

  bba_pkg::mark_t mem [bba_pkg::NUM_BLOCKS];

  logic                      clr_busy;
  logic [bba_pkg::IDX_W-1:0] clr_idx;

  logic                      wr_en;
  logic [bba_pkg::IDX_W-1:0] wr_addr;
  bba_pkg::mark_t            wr_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == bba_pkg::IDX_W'(bba_pkg::NUM_BLOCKS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_mark = bba_pkg::MARK_FREE;
    end else begin
      wr_en   = req.wr_en;
      wr_addr = req.wr_addr;
      wr_mark = req.wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_mark;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  assign clearing = clr_busy;

endmodule

/* rtl/bba_seq.sv */
// ----------------------------------------------------------------------------
// bba_seq
// Sequencer: one shared index counter drives the run search and the release
// walk over the mark memory, one mark per cycle; the run marking uses k.
// ----------------------------------------------------------------------------
module bba_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  bba_pkg::req_word_t        req_word,
  input  logic [bba_pkg::CNT_W-1:0] managed,
  input  bba_pkg::mark_t            rd_data,
  input  logic                      clearing,
  input  logic                      slot_free,
  output bba_pkg::mark_req_t        mem_req,
  output logic                      idle,
  output logic                      rsp_load,
  output bba_pkg::rsp_word_t        rsp_word
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_MARK    = 4'd3;
  localparam logic [3:0] S_REL_CHK = 4'd4;
  localparam logic [3:0] S_WALK    = 4'd5;
  localparam logic [3:0] S_DONE    = 4'd6;

  localparam int CW = bba_pkg::CNT_W;
  localparam int IW = bba_pkg::IDX_W;
  localparam logic [CW-1:0] LAST_IDX = CW'(bba_pkg::NUM_BLOCKS - 1);

  logic [3:0]                 state, state_next;
  bba_pkg::req_word_t         cur, cur_next;
  logic [CW-1:0]              need, need_next;
  logic [CW-1:0]              rd_idx, rd_idx_next;
  logic                       pv, pv_next;
  logic [IW-1:0]              pidx, pidx_next;
  logic [CW-1:0]              run, run_next;
  logic                       pass, pass_next;
  logic [IW-1:0]              at, at_next;
  logic [CW-1:0]              k, k_next;
  logic [CW-1:0]              freed, freed_next;
  logic [CW-1:0]              used_count, used_count_next;
  logic [CW-1:0]              search_pos, search_pos_next;
  logic [bba_pkg::STAT_W-1:0] res_status, res_status_next;
  logic [bba_pkg::OFF_W-1:0]  res_offset, res_offset_next;

  logic [CW-1:0]              free_now;
  logic [bba_pkg::NEED_W-1:0] need_full;
  logic [31:0]                rel_idx;
  logic                       rel_bad;
  logic [CW-1:0]              lim;
  logic                       issue;
  logic                       found;
  logic                       walk_last;
  logic [CW-1:0]              freed_inc;
  logic [CW-1:0]              run_inc;
  logic [31:0]                at_bytes;

  assign free_now  = (used_count >= managed) ? '0 : managed - used_count;
  assign need_full = {1'b0, cur.request_bytes[bba_pkg::BYTES_W-1:bba_pkg::BLK_SH]}
                     + bba_pkg::NEED_W'(|cur.request_bytes[bba_pkg::BLK_SH-1:0]);
  assign rel_idx   = 32'(cur.release_offset >> bba_pkg::BLK_SH);
  assign rel_bad   = (|cur.release_offset[bba_pkg::BLK_SH-1:0])
                     || (rel_idx >= 32'(managed));
  assign lim       = (state == S_WALK) ? CW'(bba_pkg::NUM_BLOCKS) : managed;
  assign issue     = rd_idx < lim;
  assign run_inc   = run + 1'b1;
  assign found     = pv && (rd_data == bba_pkg::MARK_FREE) && (run_inc == need);
  assign walk_last = (rd_data == bba_pkg::MARK_END) || (CW'(pidx) == LAST_IDX);
  assign freed_inc = freed + 1'b1;
  assign at_bytes  = 32'(at) << bba_pkg::BLK_SH;

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    need_next       = need;
    rd_idx_next     = rd_idx;
    pv_next         = 1'b0;
    pidx_next       = rd_idx[IW-1:0];
    run_next        = run;
    pass_next       = pass;
    at_next         = at;
    k_next          = k;
    freed_next      = freed;
    used_count_next = used_count;
    search_pos_next = search_pos;
    res_status_next = res_status;
    res_offset_next = res_offset;
    mem_req         = '0;
    rsp_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_next   = req_word;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_offset_next = '0;
        if (cur.command == bba_pkg::CMD_ALLOC) begin
          need_next = need_full[CW-1:0];
          run_next  = '0;
          if (need_full == '0 || need_full > bba_pkg::NEED_W'(free_now)) begin
            res_status_next = bba_pkg::STATUS_NOMEM;
            state_next      = S_DONE;
          end else begin
            if (search_pos < managed) begin
              rd_idx_next = search_pos;
              pass_next   = 1'b0;
            end else begin
              rd_idx_next = '0;
              pass_next   = 1'b1;
            end
            state_next = S_SCAN;
          end
        end else begin
          at_next         = rel_idx[IW-1:0];
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rel_idx[IW-1:0];
          if (rel_bad) begin
            res_status_next = bba_pkg::STATUS_IGNORED;
            state_next      = S_DONE;
          end else begin
            state_next = S_REL_CHK;
          end
        end
      end
      S_SCAN: begin
        mem_req.rd_en   = issue;
        mem_req.rd_addr = rd_idx[IW-1:0];
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        pv_next = issue && !found;
        if (pv) begin
          run_next = (rd_data == bba_pkg::MARK_FREE) ? run_inc : '0;
        end
        if (found) begin
          at_next    = IW'(CW'(pidx) + 1'b1 - need);
          k_next     = '0;
          state_next = S_MARK;
        end else if (!pv && !issue) begin
          if (!pass) begin
            pass_next   = 1'b1;
            rd_idx_next = '0;
            run_next    = '0;
          end else begin
            res_status_next = bba_pkg::STATUS_NOMEM;
            state_next      = S_DONE;
          end
        end
      end
      S_MARK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = at + IW'(k);
        if (need == CW'(1)) begin
          mem_req.wr_mark = bba_pkg::MARK_SINGLE;
        end else if (k == '0) begin
          mem_req.wr_mark = bba_pkg::MARK_START;
        end else if (k == need - 1'b1) begin
          mem_req.wr_mark = bba_pkg::MARK_END;
        end else begin
          mem_req.wr_mark = bba_pkg::MARK_USED;
        end
        k_next = k + 1'b1;
        if (k == need - 1'b1) begin
          used_count_next = used_count + need;
          search_pos_next = CW'(at) + need;
          res_offset_next = at_bytes[bba_pkg::OFF_W-1:0];
          res_status_next = bba_pkg::STATUS_DONE;
          state_next      = S_DONE;
        end
      end
      S_REL_CHK: begin
        mem_req.wr_addr = at;
        mem_req.wr_mark = bba_pkg::MARK_FREE;
        if (rd_data == bba_pkg::MARK_SINGLE
            || (rd_data == bba_pkg::MARK_START && CW'(at) == LAST_IDX)) begin
          mem_req.wr_en   = 1'b1;
          used_count_next = (used_count != '0) ? used_count - 1'b1 : '0;
          res_status_next = bba_pkg::STATUS_DONE;
          state_next      = S_DONE;
        end else if (rd_data == bba_pkg::MARK_START) begin
          mem_req.wr_en = 1'b1;
          freed_next    = CW'(1);
          rd_idx_next   = CW'(at) + 1'b1;
          state_next    = S_WALK;
        end else begin
          res_status_next = bba_pkg::STATUS_IGNORED;
          state_next      = S_DONE;
        end
      end
      S_WALK: begin
        mem_req.rd_en   = issue;
        mem_req.rd_addr = rd_idx[IW-1:0];
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        pv_next         = issue && !(pv && walk_last);
        mem_req.wr_addr = pidx;
        mem_req.wr_mark = bba_pkg::MARK_FREE;
        if (pv) begin
          mem_req.wr_en = 1'b1;
          freed_next    = freed_inc;
          if (walk_last) begin
            used_count_next = (used_count >= freed_inc) ? used_count - freed_inc : '0;
            res_status_next = bba_pkg::STATUS_DONE;
            state_next      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pv         <= 1'b0;
      used_count <= '0;
      search_pos <= '0;
    end else begin
      state      <= state_next;
      pv         <= pv_next;
      used_count <= used_count_next;
      search_pos <= search_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    need       <= need_next;
    rd_idx     <= rd_idx_next;
    pidx       <= pidx_next;
    run        <= run_next;
    pass       <= pass_next;
    at         <= at_next;
    k          <= k_next;
    freed      <= freed_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
  end

  assign idle                  = (state == S_IDLE) && !clearing;
  assign rsp_word.status       = res_status;
  assign rsp_word.alloc_offset = res_offset;
  assign rsp_word.used_blocks  = bba_pkg::OCNT_W'(used_count);
  assign rsp_word.free_blocks  = bba_pkg::OCNT_W'(free_now);

endmodule

/* rtl/bitmap_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// Next-fit block allocator over a heap of fixed-size blocks.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  req      in   valid/ready   command, request_bytes, release_offset
//  rsp      out  valid/ready   status, alloc_offset, used_blocks, free_blocks
//  cfg      in   valid/ready   data (managed_blocks)
//
//  Allocate: the search reads one mark per cycle through the single read port
//  of the mark memory, then writes the run.
//  Release: a single block is freed at once; a run is walked to its end mark.
//  Reset starts a clearing pass over all NUM_BLOCKS marks; req.ready stays low.
//  A finished word waits in the response register; the next request is taken
//  meanwhile and its result waits until that register empties.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core (
  input logic clk,
  input logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);

  logic [bba_pkg::CFG_W-1:0] managed_blocks;
  logic [bba_pkg::CNT_W-1:0] managed;

  bba_pkg::req_word_t  req_word;
  bba_pkg::rsp_word_t  seq_rsp;
  bba_pkg::rsp_word_t  rsp_q;
  bba_pkg::mark_req_t  mem_req;
  bba_pkg::mark_t      rd_data;
  logic                clearing;
  logic                idle;
  logic                rsp_load;
  logic                rsp_valid;
  logic                slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      managed_blocks <= bba_pkg::CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      managed_blocks <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign managed   = (32'(managed_blocks) > 32'(bba_pkg::NUM_BLOCKS))
                     ? bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS)
                     : bba_pkg::CNT_W'(managed_blocks);

  assign req_word.command        = req.command;
  assign req_word.request_bytes  = req.request_bytes;
  assign req_word.release_offset = req.release_offset;
  assign req.ready               = idle;

  assign slot_free = !rsp_valid || rsp.ready;

  bba_mark_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  bba_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && req.ready),
    .req_word  (req_word),
    .managed   (managed),
    .rd_data   (rd_data),
    .clearing  (clearing),
    .slot_free (slot_free),
    .mem_req   (mem_req),
    .idle      (idle),
    .rsp_load  (rsp_load),
    .rsp_word  (seq_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_q <= seq_rsp;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_q.status;
  assign rsp.alloc_offset = rsp_q.alloc_offset;
  assign rsp.used_blocks  = rsp_q.used_blocks;
  assign rsp.free_blocks  = rsp_q.free_blocks;

  a_clear_blocks_req: assert property (@(posedge clk) $fell(rst) |-> !req.ready)
    else $error("request taken during clearing pass");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.free_blocks == '0
                   || 32'(rsp.used_blocks) + 32'(rsp.free_blocks) == 32'(managed)))
    else $error("used and free counts disagree with managed count");

  a_offset_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.alloc_offset[bba_pkg::BLK_SH-1:0] == '0)
    else $error("allocated offset not block aligned");

  a_fail_no_offset: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != bba_pkg::STATUS_DONE) |-> rsp.alloc_offset == '0)
    else $error("offset reported on failed request");

endmodule
